// ===== rtl/psl_pkg.sv =====
// Shared types, constants and helpers for the packet sequence loss monitor.
package psl_pkg;

  localparam int unsigned ADDR_REGS       = 6;
  localparam int unsigned NUM_SOURCES_DEF = 6;
  localparam int unsigned CNT_W           = 32;
  localparam int unsigned ADDR_W          = 32;
  localparam int unsigned SEQ_W           = 32;
  localparam int unsigned LEN_W           = 16;
  localparam int unsigned TIME_W          = 32;
  localparam int unsigned SRC_IDX_W       = 3;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_IDX = 3'd6;
  localparam logic [TIME_W-1:0]    THRESH_RESET   = 32'd1000;
  localparam logic [CNT_W-1:0]     CNT_MAX        = '1;

  // Input beat, first field in the highest bits
  typedef struct packed {
    logic [TIME_W-1:0] arrival_time_us;
    logic [LEN_W-1:0]  packet_length;
    logic [SEQ_W-1:0]  sequence_number;
    logic [ADDR_W-1:0] sender_address;
  } psl_item_t;

  // Result beat, first field in the highest bits
  typedef struct packed {
    logic [CNT_W-1:0]     packets_total;
    logic [CNT_W-1:0]     size_total;
    logic [CNT_W-1:0]     late_total;
    logic [CNT_W-1:0]     missing_total;
    logic                 late_arrival;
    logic                 sequence_gap;
    logic                 size_mismatch;
    logic                 first_seen;
    logic [SRC_IDX_W-1:0] source_index;
    logic                 known_source;
  } psl_result_t;

  localparam int unsigned ITEM_W   = $bits(psl_item_t);
  localparam int unsigned RESULT_W = $bits(psl_result_t);

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

// ===== rtl/psl_cfg.sv =====
// Configuration register file: source addresses and late threshold.
module psl_cfg #(
  parameter int unsigned NUM_ACTIVE = psl_pkg::ADDR_REGS
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       cfg_we_i,
  input  logic [psl_pkg::CFG_IDX_W-1:0]              cfg_idx_i,
  input  logic [psl_pkg::CFG_DATA_W-1:0]             cfg_data_i,
  output logic [NUM_ACTIVE-1:0][psl_pkg::ADDR_W-1:0] src_addr_o,
  output logic [psl_pkg::TIME_W-1:0]                 late_thresh_o
);
  import psl_pkg::*;

  logic [NUM_ACTIVE-1:0][ADDR_W-1:0] src_addr_q;
  logic [TIME_W-1:0]                 late_thresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_addr_q    <= '0;
      late_thresh_q <= THRESH_RESET;
    end else if (cfg_we_i) begin
      // writes to unused indexes fall through and are dropped
      for (int i = 0; i < NUM_ACTIVE; i++) begin
        if (cfg_idx_i == CFG_IDX_W'(i)) begin
          src_addr_q[i] <= cfg_data_i[ADDR_W-1:0];
        end
      end
      if (cfg_idx_i == CFG_THRESH_IDX) begin
        late_thresh_q <= cfg_data_i[TIME_W-1:0];
      end
    end
  end

  assign src_addr_o    = src_addr_q;
  assign late_thresh_o = late_thresh_q;

endmodule

// ===== rtl/psl_track.sv =====
// Per-source tracking table: address match, checks and saturating counters.
module psl_track #(
  parameter int unsigned NUM_ACTIVE = psl_pkg::ADDR_REGS
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       upd_i,
  input  psl_pkg::psl_item_t                         item_i,
  input  logic [NUM_ACTIVE-1:0][psl_pkg::ADDR_W-1:0] src_addr_i,
  input  logic [psl_pkg::TIME_W-1:0]                 late_thresh_i,
  output psl_pkg::psl_result_t                       result_o
);
  import psl_pkg::*;

  localparam int unsigned IDX_W = (NUM_ACTIVE > 1) ? $clog2(NUM_ACTIVE) : 1;

  logic [NUM_ACTIVE-1:0]             seen_q;
  logic [NUM_ACTIVE-1:0][LEN_W-1:0]  first_len_q;
  logic [NUM_ACTIVE-1:0][SEQ_W-1:0]  last_seq_q;
  logic [NUM_ACTIVE-1:0][TIME_W-1:0] last_arr_q;
  logic [NUM_ACTIVE-1:0][CNT_W-1:0]  gap_cnt_q;
  logic [NUM_ACTIVE-1:0][CNT_W-1:0]  late_cnt_q;
  logic [NUM_ACTIVE-1:0][CNT_W-1:0]  size_cnt_q;
  logic [NUM_ACTIVE-1:0][CNT_W-1:0]  pkt_cnt_q;

  logic              hit;
  logic [IDX_W-1:0]  idx;
  logic              seen;
  logic              size_err;
  logic              gap_err;
  logic              late_err;
  logic [SEQ_W-1:0]  seq_diff;
  logic [TIME_W-1:0] arr_diff;
  logic [CNT_W-1:0]  gap_cnt_d;
  logic [CNT_W-1:0]  late_cnt_d;
  logic [CNT_W-1:0]  size_cnt_d;
  logic [CNT_W-1:0]  pkt_cnt_d;

  // Lowest matching index wins: scan from the top down
  always_comb begin
    hit = 1'b0;
    idx = '0;
    for (int i = NUM_ACTIVE - 1; i >= 0; i--) begin
      if (src_addr_i[i] == item_i.sender_address) begin
        hit = 1'b1;
        idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    seen       = seen_q[idx];
    seq_diff   = item_i.sequence_number - last_seq_q[idx];
    arr_diff   = item_i.arrival_time_us - last_arr_q[idx];
    size_err   = seen && (first_len_q[idx] != item_i.packet_length);
    gap_err    = seen && (seq_diff != SEQ_W'(1));
    late_err   = seen && (arr_diff >= late_thresh_i);
    gap_cnt_d  = gap_err  ? sat_inc(gap_cnt_q[idx])  : gap_cnt_q[idx];
    late_cnt_d = late_err ? sat_inc(late_cnt_q[idx]) : late_cnt_q[idx];
    size_cnt_d = size_err ? sat_inc(size_cnt_q[idx]) : size_cnt_q[idx];
    pkt_cnt_d  = sat_inc(pkt_cnt_q[idx]);

    result_o = '0;
    if (hit) begin
      result_o.known_source  = 1'b1;
      result_o.source_index  = SRC_IDX_W'(idx);
      result_o.first_seen    = !seen;
      result_o.size_mismatch = size_err;
      result_o.sequence_gap  = gap_err;
      result_o.late_arrival  = late_err;
      result_o.missing_total = gap_cnt_d;
      result_o.late_total    = late_cnt_d;
      result_o.size_total    = size_cnt_d;
      result_o.packets_total = pkt_cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      first_len_q <= '0;
      last_seq_q  <= '0;
      last_arr_q  <= '0;
      gap_cnt_q   <= '0;
      late_cnt_q  <= '0;
      size_cnt_q  <= '0;
      pkt_cnt_q   <= '0;
    end else if (upd_i && hit) begin
      if (!seen) begin
        seen_q[idx]      <= 1'b1;
        first_len_q[idx] <= item_i.packet_length;
      end
      last_seq_q[idx] <= item_i.sequence_number;
      last_arr_q[idx] <= item_i.arrival_time_us;
      gap_cnt_q[idx]  <= gap_cnt_d;
      late_cnt_q[idx] <= late_cnt_d;
      size_cnt_q[idx] <= size_cnt_d;
      pkt_cnt_q[idx]  <= pkt_cnt_d;
    end
  end

endmodule

// ===== rtl/packet_sequence_loss_monitor.sv =====
// A packet beat is held in the input register, and its result beat is registered
// into the result register once that is free or drained. Throughput: one packet
// per cycle while the result register is free or drained; the lookup, checks and
// counter update of a packet sit in one stage between the input and result registers.
// Reset clears all per-source state and counters, the source addresses to zero
// and the late threshold to 1000 us.
module packet_sequence_loss_monitor #(
  parameter int unsigned NUM_SOURCES = psl_pkg::NUM_SOURCES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // sender_address, sequence_number, packet_length, arrival_time_us
  input  logic [psl_pkg::ITEM_W-1:0]       s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // known_source, source_index, first_seen, size_mismatch, sequence_gap,
  // late_arrival, missing_total, late_total, size_total, packets_total
  output logic [psl_pkg::RESULT_W-1:0]     m_axis_tdata,
  input  logic                             cfg_we_i,
  input  logic [psl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [psl_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import psl_pkg::*;

  localparam int unsigned NUM_ACTIVE = (NUM_SOURCES < ADDR_REGS) ? NUM_SOURCES : ADDR_REGS;

  logic [NUM_ACTIVE-1:0][ADDR_W-1:0] src_addr;
  logic [TIME_W-1:0]                 late_thresh;

  logic        in_valid_q;
  psl_item_t   in_q;
  logic        out_valid_q;
  psl_result_t out_q;
  psl_result_t result;
  logic        advance;

  // The compute stage moves whenever the result register is free or drained
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= psl_item_t'(s_axis_tdata);
    end
    if (advance && in_valid_q) begin
      out_q <= result;
    end
  end

  psl_cfg #(
    .NUM_ACTIVE (NUM_ACTIVE)
  ) u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .src_addr_o    (src_addr),
    .late_thresh_o (late_thresh)
  );

  psl_track #(
    .NUM_ACTIVE (NUM_ACTIVE)
  ) u_track (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .upd_i         (advance && in_valid_q),
    .item_i        (in_q),
    .src_addr_i    (src_addr),
    .late_thresh_i (late_thresh),
    .result_o      (result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  a_unknown_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.known_source |->
      out_q.packets_total == '0 && out_q.source_index == '0 && !out_q.first_seen)
    else $error("unknown sender result carries source data");

  a_first_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.first_seen |->
      !out_q.size_mismatch && !out_q.sequence_gap && !out_q.late_arrival &&
      out_q.packets_total == CNT_W'(1))
    else $error("first packet of a source raised an error or miscounted");

  a_known_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.known_source |-> out_q.packets_total != '0)
    else $error("known source result with zero packet count");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_q))
    else $error("compute stage lost a beat while stalled");

endmodule
